[src/gld_pkg.sv]
`default_nettype none
package gld_pkg;
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_EMIT,
        ST_HOLD
    } state_t;
endpackage
`default_nettype wire

[src/gif_lzw_decoder_top.sv]
// A clear or end code, or the first code after a clear, gives its one result in the cycle after
// it is accepted. Any other code walks its chain link by link (table read, then stack push),
// then finds the root, then emits one pixel per cycle within a result; a result holds up to
// PIXELS_PER_RESULT (32) pixels, and a longer string is split into results of 32 pixels.
// One code is handled at a time; the next code is taken the cycle after its last result goes.
// Reset starts a pass that zeroes every dictionary entry; no code is taken during it.
`default_nettype none
module gif_lzw_decoder_top #(
    parameter int MAX_CODE_BITS     = 12,
    parameter int TABLE_ENTRIES     = 4096,
    parameter int STACK_DEPTH       = 1024,
    parameter int PIXELS_PER_RESULT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [11:0] code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      pixels_a,
    output logic [63:0]      pixels_b,
    output logic [63:0]      pixels_c,
    output logic [63:0]      pixels_d,
    output logic [5:0]       pixel_count,
    output logic             last_of_run,
    output logic             end_of_image,
    output logic             decode_error,
    output logic [3:0]       next_code_width
);
    import gld_pkg::*;

    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(PIXELS_PER_RESULT);

    logic [11:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]  suffix_mem [TABLE_ENTRIES];
    logic [7:0]  stack_mem  [STACK_DEPTH];

    state_t state_reg, state_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [3:0]  mcs_reg, mcs_next, cd_reg, cd_next;
    logic [11:0] prev_reg, prev_next;
    logic [7:0]  root_reg, root_next;
    logic [12:0] nfc_reg, nfc_next;
    logic [3:0]  cw_reg, cw_next;
    logic        ac_reg, ac_next, err_reg, err_next;
    logic [11:0] cur_reg, cur_next;
    logic [SW:0] depth_reg, depth_next;
    logic [SW:0] pop_reg, pop_next;
    logic [PW:0] cnt_reg, cnt_next;
    logic        eoi_reg, eoi_next;
    logic        done_reg, done_next;
    logic [7:0]  pix_reg [PIXELS_PER_RESULT];
    logic [11:0] code_reg, code_next;

    logic [11:0] pre_rd;
    logic [7:0]  suf_rd, stk_rd;
    logic [TW-1:0] rd_addr;
    logic        tbl_we;
    logic [TW-1:0] tbl_waddr;
    logic [11:0] tbl_wpre;
    logic [7:0]  tbl_wsuf;
    logic        stk_we;
    logic [SW-1:0] stk_waddr, stk_raddr;
    logic [7:0]  stk_wdata;
    logic        pix_we, pix_clr;
    logic [PW-1:0] pix_waddr;
    logic [7:0]  pix_wdata;

    logic [3:0]  msize;
    logic [7:0]  mask;
    logic [12:0] clear_code;
    logic        stk_rvalid_reg;

    always_comb
    begin
        msize = (mcs_reg < 4'd2) ? 4'd2 : ((mcs_reg > 4'd8) ? 4'd8 : mcs_reg);
        mask = 8'hff >> (4'd8 - ((cd_reg < 4'd1) ? 4'd1 : ((cd_reg > 4'd8) ? 4'd8 : cd_reg)));
        clear_code = 13'd1 << msize;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            prefix_mem[tbl_waddr] <= tbl_wpre;
            suffix_mem[tbl_waddr] <= tbl_wsuf;
        end
        pre_rd <= prefix_mem[rd_addr];
        suf_rd <= suffix_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PIXELS_PER_RESULT; i++)
        begin
            if (pix_we && (pix_waddr == PW'(i)))
            begin
                pix_reg[i] <= pix_wdata;
            end
            else if (pix_clr)
            begin
                pix_reg[i] <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            mcs_reg <= 4'd8;
            cd_reg <= 4'd8;
            prev_reg <= '0;
            root_reg <= '0;
            nfc_reg <= 13'd258;
            cw_reg <= 4'd9;
            ac_reg <= 1'b0;
            err_reg <= 1'b0;
            cur_reg <= '0;
            depth_reg <= '0;
            pop_reg <= '0;
            cnt_reg <= '0;
            eoi_reg <= 1'b0;
            done_reg <= 1'b0;
            code_reg <= '0;
            stk_rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            mcs_reg <= mcs_next;
            cd_reg <= cd_next;
            prev_reg <= prev_next;
            root_reg <= root_next;
            nfc_reg <= nfc_next;
            cw_reg <= cw_next;
            ac_reg <= ac_next;
            err_reg <= err_next;
            cur_reg <= cur_next;
            depth_reg <= depth_next;
            pop_reg <= pop_next;
            cnt_reg <= cnt_next;
            eoi_reg <= eoi_next;
            done_reg <= done_next;
            code_reg <= code_next;
            // A resumed run re-enters ST_EMIT with the stack read for pop already held.
            stk_rvalid_reg <= (state_next == ST_EMIT) &&
                              ((state_reg == ST_EMIT) || (state_reg == ST_HOLD));
        end
    end

    logic [11:0] walk_cur;
    logic        hold_full;
    logic [3:0]  ms_new;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        mcs_next = mcs_reg;
        cd_next = cd_reg;
        prev_next = prev_reg;
        root_next = root_reg;
        nfc_next = nfc_reg;
        cw_next = cw_reg;
        ac_next = ac_reg;
        err_next = err_reg;
        cur_next = cur_reg;
        depth_next = depth_reg;
        pop_next = pop_reg;
        cnt_next = cnt_reg;
        eoi_next = eoi_reg;
        done_next = done_reg;
        code_next = code_reg;
        in_stall = 1'b1;
        rd_addr = cur_reg[TW-1:0];
        tbl_we = 1'b0;
        tbl_waddr = clr_reg;
        tbl_wpre = '0;
        tbl_wsuf = '0;
        stk_we = 1'b0;
        stk_waddr = depth_reg[SW-1:0];
        stk_wdata = suf_rd;
        stk_raddr = pop_reg[SW-1:0];
        pix_we = 1'b0;
        pix_clr = 1'b0;
        pix_waddr = cnt_reg[PW-1:0];
        pix_wdata = stk_rd;
        walk_cur = pre_rd;
        hold_full = 1'b0;
        ms_new = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                tbl_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TW'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    code_next = code;
                    pix_clr = 1'b1;
                    cnt_next = '0;
                    eoi_next = 1'b0;
                    done_next = 1'b1;
                    if ({1'b0, code} == clear_code)
                    begin
                        cw_next = msize + 4'd1;
                        nfc_next = clear_code + 13'd2;
                        ac_next = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else if ({1'b0, code} == clear_code + 13'd1)
                    begin
                        prev_next = '0;
                        root_next = '0;
                        nfc_next = clear_code + 13'd2;
                        cw_next = msize + 4'd1;
                        ac_next = 1'b0;
                        eoi_next = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else if (ac_reg)
                    begin
                        ac_next = 1'b0;
                        prev_next = code;
                        root_next = code[7:0] & mask;
                        pix_we = 1'b1;
                        pix_waddr = '0;
                        pix_wdata = code[7:0] & mask;
                        cnt_next = (PW+1)'(1);
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        if ({1'b0, code} >= nfc_reg)
                        begin
                            cur_next = prev_reg;
                            stk_we = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = root_reg;
                            depth_next = (SW+1)'(1);
                        end
                        else
                        begin
                            cur_next = code;
                            depth_next = '0;
                        end
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // The table read for cur is issued here; its data returns in ST_LAST.
                if (cur_reg <= {4'd0, mask})
                begin
                    root_next = cur_reg[7:0] & mask;
                    state_next = ST_EMIT;
                end
                else if (depth_reg >= (SW+1)'(STACK_DEPTH))
                begin
                    err_next = 1'b1;
                    root_next = cur_reg[7:0] & mask;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                stk_we = 1'b1;
                stk_wdata = suf_rd;
                depth_next = depth_reg + 1'b1;
                cur_next = walk_cur;
                rd_addr = walk_cur[TW-1:0];
                state_next = ST_WALK;
            end
            ST_EMIT:
            begin
                // First cycle: write root and, while the table has room, a table entry; then pop stack one per cycle.
                if (!stk_rvalid_reg)
                begin
                    pix_we = 1'b1;
                    pix_wdata = root_next;
                    cnt_next = (PW+1)'(1);
                    pop_next = depth_reg - 1'b1;
                    stk_raddr = pop_next[SW-1:0];
                    if (nfc_reg < 13'(TABLE_ENTRIES))
                    begin
                        tbl_we = 1'b1;
                        tbl_waddr = nfc_reg[TW-1:0];
                        tbl_wpre = prev_reg;
                        tbl_wsuf = root_reg;
                        nfc_next = nfc_reg + 13'd1;
                        if (nfc_next >= (13'd1 << cw_reg) && cw_reg < 4'(MAX_CODE_BITS))
                        begin
                            cw_next = cw_reg + 4'd1;
                        end
                    end
                    prev_next = code_reg;
                    done_next = (depth_reg == '0);
                    if (depth_reg == '0)
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    pix_we = 1'b1;
                    pix_wdata = stk_rd;
                    cnt_next = cnt_reg + 1'b1;
                    pop_next = pop_reg - 1'b1;
                    stk_raddr = pop_next[SW-1:0];
                    depth_next = depth_reg - 1'b1;
                    done_next = (depth_reg == (SW+1)'(1));
                    if (depth_reg == (SW+1)'(1) ||
                        cnt_reg == (PW+1)'(PIXELS_PER_RESULT - 1))
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                hold_full = 1'b1;
                if (!out_stall)
                begin
                    if (done_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pix_clr = 1'b1;
                        cnt_next = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == 1'b0)
            begin
                mcs_next = cfg_data;
                ms_new = (cfg_data < 4'd2) ? 4'd2 : ((cfg_data > 4'd8) ? 4'd8 : cfg_data);
                prev_next = '0;
                root_next = '0;
                nfc_next = (13'd1 << ms_new) + 13'd2;
                cw_next = ms_new + 4'd1;
                ac_next = 1'b0;
            end
            else
            begin
                cd_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        out_valid = hold_full;
        pixel_count = 6'(cnt_reg);
        last_of_run = done_reg;
        end_of_image = eoi_reg;
        decode_error = err_reg;
        next_code_width = cw_reg;
        for (int i = 0; i < 8; i++)
        begin
            pixels_a[8*i +: 8] = pix_reg[i];
            pixels_b[8*i +: 8] = (i + 8 < PIXELS_PER_RESULT) ? pix_reg[(i + 8) % PIXELS_PER_RESULT] : 8'd0;
            pixels_c[8*i +: 8] = (i + 16 < PIXELS_PER_RESULT) ? pix_reg[(i + 16) % PIXELS_PER_RESULT] : 8'd0;
            pixels_d[8*i +: 8] = (i + 24 < PIXELS_PER_RESULT) ? pix_reg[(i + 24) % PIXELS_PER_RESULT] : 8'd0;
        end
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != ST_IDLE) |-> in_stall;
    endproperty
    assert property (p_no_accept_busy) else $error("code accepted while busy");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) out_valid |-> (pixel_count <= 6'(PIXELS_PER_RESULT));
    endproperty
    assert property (p_count_bound) else $error("pixel count too large");

    property p_err_sticky;
        @(posedge clk) disable iff (!rst_n) $past(err_reg) |-> err_reg;
    endproperty
    assert property (p_err_sticky) else $error("error flag dropped");

    property p_width_bound;
        @(posedge clk) disable iff (!rst_n) cw_reg <= 4'(MAX_CODE_BITS);
    endproperty
    assert property (p_width_bound) else $error("code width too large");
endmodule
`default_nettype wire
